// ===== rtl/mwo_pkg.sv =====
package mwo_pkg;

  localparam int PH_W = 32;
  localparam int PHASE_FRAC_BITS_DEFAULT = 24;
  localparam int SINE_TABLE_BITS_DEFAULT = 10;

  // Q1.30 operand width, holds 0 .. 1.0
  localparam int XW = 31;

  localparam int ST_PHASE    = 0;
  localparam int ST_SHAPE    = 2;
  localparam int ST_SINE     = 3;
  localparam int SINE_STAGES = 12;
  localparam int ST_OUT      = ST_SINE + SINE_STAGES;
  localparam int NUM_STAGES  = ST_OUT + 1;

  typedef enum logic [1:0] {
    OP_SINE     = 2'd0,
    OP_SAW      = 2'd1,
    OP_SQUARE   = 2'd2,
    OP_TRIANGLE = 2'd3
  } op_t;

  localparam logic signed [47:0] RAD_TO_CYCLE = 48'sd683565276;
  localparam logic [XW-1:0] Q30_ONE = 31'h4000_0000;

  localparam logic signed [31:0] SIN_A9 = 32'sd172272;
  localparam logic signed [31:0] SIN_COEF [4] = '{
    -32'sd5026995,
    32'sd85569306,
    -32'sd693598668,
    32'sd1686629713
  };

  // divide by 2^30, rounding toward zero
  function automatic logic signed [63:0] trunc_q30(input logic signed [63:0] v);
    logic signed [63:0] bias;
    bias = v[63] ? 64'sd1073741823 : 64'sd0;
    return (v + bias) >>> 30;
  endfunction

endpackage

// ===== rtl/mwo_phase.sv =====
module mwo_phase #(
  parameter int PHASE_FRAC_BITS = mwo_pkg::PHASE_FRAC_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  mwo_pkg::op_t            op,
  input  logic [31:0]             time_value,
  input  logic [31:0]             frequency,
  input  logic signed [23:0]      phase_offset,
  output mwo_pkg::op_t            op_o,
  output logic [mwo_pkg::PH_W-1:0] ph_o
);

  localparam int PH_W = mwo_pkg::PH_W;
  localparam logic [PH_W:0] LOW_BITS = (33'd1 << (PH_W - PHASE_FRAC_BITS)) - 33'd1;
  localparam logic [PH_W-1:0] PH_MASK = ~LOW_BITS[PH_W-1:0];

  logic [PH_W-1:0]       tf_r;
  logic [PH_W-1:0]       offc_r;
  mwo_pkg::op_t          op0_r;
  logic [PH_W-1:0]       ph_r;
  mwo_pkg::op_t          op1_r;
  logic signed [47:0]    rad_prod;
  logic [PH_W-1:0]       offc_nxt;

  always_comb begin
    rad_prod = 48'(phase_offset) * mwo_pkg::RAD_TO_CYCLE;
    if (op == mwo_pkg::OP_SINE) begin
      offc_nxt = rad_prod[47:16];
    end else begin
      offc_nxt = {phase_offset[15:0], 16'h0000};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tf_r   <= time_value * frequency;
      offc_r <= offc_nxt;
      op0_r  <= op;
    end
    if (en[1]) begin
      ph_r  <= (tf_r + offc_r) & PH_MASK;
      op1_r <= op0_r;
    end
  end

  assign ph_o = ph_r;
  assign op_o = op1_r;

endmodule

// ===== rtl/mwo_shape.sv =====
module mwo_shape #(
  parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      en,
  input  mwo_pkg::op_t              op,
  input  logic [mwo_pkg::PH_W-1:0]  ph,
  output mwo_pkg::op_t              op_o,
  output logic [mwo_pkg::XW-1:0]    x_o,
  output logic [1:0]                quad_o,
  output logic signed [15:0]        smp_o
);

  localparam int PH_W = mwo_pkg::PH_W;
  localparam int XW = mwo_pkg::XW;

  logic [SINE_TABLE_BITS-1:0] n;
  logic [XW-1:0]              xr;
  logic [XW-1:0]              x_nxt;
  logic signed [33:0]         ty;
  logic [33:0]                ty_abs;
  logic [31:0]                d;
  logic signed [17:0]         tri_s;
  logic signed [15:0]         smp_nxt;

  mwo_pkg::op_t               op_r;
  logic [XW-1:0]              x_r;
  logic [1:0]                 quad_r;
  logic signed [15:0]         smp_r;

  always_comb begin
    n  = ph[PH_W-1 -: SINE_TABLE_BITS];
    xr = {1'b0, n[SINE_TABLE_BITS-3:0], {(PH_W - SINE_TABLE_BITS){1'b0}}};
    if (n[SINE_TABLE_BITS-2]) begin
      x_nxt = mwo_pkg::Q30_ONE - xr;
    end else begin
      x_nxt = xr;
    end

    // triangle: distance of phase - 0.25 to the nearest integer
    ty     = $signed({2'b00, ph}) - 34'sh0_4000_0000;
    ty_abs = 34'(-ty);
    if (ty < 0) begin
      d = ty_abs[31:0];
    end else if (ty <= 34'sh0_8000_0000) begin
      d = ty[31:0];
    end else begin
      ty_abs = 34'(34'sh1_0000_0000 - ty);
      d      = ty_abs[31:0];
    end
    tri_s = 18'sd32768 - $signed({1'b0, d[31:15]});

    case (op)
      mwo_pkg::OP_SAW:    smp_nxt = $signed(ph[31:16]);
      mwo_pkg::OP_SQUARE: smp_nxt = ph[31] ? -16'sd32768 : 16'sd32767;
      mwo_pkg::OP_TRIANGLE: begin
        if (tri_s > 18'sd32767) begin
          smp_nxt = 16'sd32767;
        end else begin
          smp_nxt = tri_s[15:0];
        end
      end
      default:            smp_nxt = 16'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r   <= op;
      x_r    <= x_nxt;
      quad_r <= n[SINE_TABLE_BITS-1 -: 2];
      smp_r  <= smp_nxt;
    end
  end

  assign op_o   = op_r;
  assign x_o    = x_r;
  assign quad_o = quad_r;
  assign smp_o  = smp_r;

endmodule

// ===== rtl/mwo_sine.sv =====
module mwo_sine (
  input  logic                              clk,
  input  logic [mwo_pkg::SINE_STAGES-1:0]   en,
  input  logic [mwo_pkg::XW-1:0]            x,
  input  logic [1:0]                        quad,
  output logic signed [15:0]                q_o
);

  localparam int XW = mwo_pkg::XW;

  logic [XW-1:0]       x_r    [0:8];
  logic [1:0]          quad_r [0:10];
  logic [XW-1:0]       x2_r   [1:6];
  logic [2*XW-2:0]     xx_r;
  logic signed [63:0]  prod_r [0:3];
  logic signed [31:0]  p_r    [0:3];
  logic signed [63:0]  yp_r;
  logic [XW-1:0]       y_r;
  logic signed [15:0]  q_r;

  logic signed [63:0]  y_t;
  logic [XW-1:0]       y_nxt;
  logic [XW-1:0]       rnd;
  logic [14:0]         qs;
  logic signed [15:0]  q_nxt;

  // x and quadrant travel alongside the polynomial
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx_r      <= {{(XW-1){1'b0}}, x} * {{(XW-1){1'b0}}, x};
      x_r[0]    <= x;
      quad_r[0] <= quad;
    end
    if (en[1]) begin
      x2_r[1] <= xx_r[2*XW-2:XW-1];
    end
  end

  for (genvar i = 1; i <= 8; i++) begin : g_x
    always_ff @(posedge clk) begin
      if (en[i]) begin
        x_r[i] <= x_r[i-1];
      end
    end
  end

  for (genvar i = 1; i <= 10; i++) begin : g_quad
    always_ff @(posedge clk) begin
      if (en[i]) begin
        quad_r[i] <= quad_r[i-1];
      end
    end
  end

  for (genvar i = 2; i <= 6; i++) begin : g_x2
    always_ff @(posedge clk) begin
      if (en[i]) begin
        x2_r[i] <= x2_r[i-1];
      end
    end
  end

  // horner steps: multiply stage, then truncate and add stage
  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic signed [63:0] acc;

    if (j == 0) begin : g_first
      assign mul_a = 64'(mwo_pkg::SIN_A9);
      assign mul_b = 64'($signed({1'b0, xx_r[2*XW-2:XW-1]}));
    end else begin : g_next
      assign mul_a = 64'(p_r[j-1]);
      assign mul_b = 64'($signed({1'b0, x2_r[2*j]}));
    end

    assign acc = 64'(mwo_pkg::SIN_COEF[j]) + mwo_pkg::trunc_q30(prod_r[j]);

    always_ff @(posedge clk) begin
      if (en[1 + 2*j]) begin
        prod_r[j] <= mul_a * mul_b;
      end
      if (en[2 + 2*j]) begin
        p_r[j] <= acc[31:0];
      end
    end
  end

  always_comb begin
    y_t = mwo_pkg::trunc_q30(yp_r);
    if (y_t < 0) begin
      y_nxt = '0;
    end else if (y_t > 64'(mwo_pkg::Q30_ONE)) begin
      y_nxt = mwo_pkg::Q30_ONE;
    end else begin
      y_nxt = y_t[XW-1:0];
    end

    rnd = y_r + 31'd16384;
    if (rnd[30:15] > 16'd32767) begin
      qs = 15'h7fff;
    end else begin
      qs = rnd[29:15];
    end
    if (quad_r[10][1]) begin
      q_nxt = -$signed({1'b0, qs});
    end else begin
      q_nxt = $signed({1'b0, qs});
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      yp_r <= 64'($signed({1'b0, x_r[8]})) * 64'(p_r[3]);
    end
    if (en[10]) begin
      y_r <= y_nxt;
    end
    if (en[11]) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== rtl/multi_waveform_oscillator.sv =====
// channel  direction  ports
// in       input      in_valid, in_ready, in_op, in_time_value, in_frequency, in_phase_offset
// out      output     out_valid, out_ready, out_sample
//
// sixteen register stages, one word accepted per cycle while in_ready is high
// the depth is set by the sine polynomial: six chained multiplies, four of them
// followed by a truncate and add stage, then clamp and round stages
// synchronous active-low reset clears the stage valid bits only
// each stage holds its word while the stage after it is full and stalled,
// so bubbles close up and in_ready stays high until every stage is full
module multi_waveform_oscillator #(
  parameter int PHASE_FRAC_BITS = mwo_pkg::PHASE_FRAC_BITS_DEFAULT,
  parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_time_value,
  input  logic [31:0]        in_frequency,
  input  logic signed [23:0] in_phase_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample
);

  localparam int NST = mwo_pkg::NUM_STAGES;
  localparam int NSS = mwo_pkg::SINE_STAGES;

  logic [NST-1:0]        valid_r;
  logic [NST-1:0]        valid_nxt;
  logic [NST:0]          en;

  mwo_pkg::op_t          ph_op;
  logic [mwo_pkg::PH_W-1:0] ph;
  mwo_pkg::op_t          sh_op;
  logic [mwo_pkg::XW-1:0] sh_x;
  logic [1:0]            sh_quad;
  logic signed [15:0]    sh_smp;
  logic signed [15:0]    sine_q;

  mwo_pkg::op_t          side_op_r  [0:NSS-1];
  logic signed [15:0]    side_smp_r [0:NSS-1];
  logic signed [15:0]    sample_r;

  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NST; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  mwo_phase #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_phase (
    .clk          (clk),
    .en           (en[mwo_pkg::ST_PHASE +: 2]),
    .op           (mwo_pkg::op_t'(in_op)),
    .time_value   (in_time_value),
    .frequency    (in_frequency),
    .phase_offset (in_phase_offset),
    .op_o         (ph_op),
    .ph_o         (ph)
  );

  mwo_shape #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_shape (
    .clk    (clk),
    .en     (en[mwo_pkg::ST_SHAPE]),
    .op     (ph_op),
    .ph     (ph),
    .op_o   (sh_op),
    .x_o    (sh_x),
    .quad_o (sh_quad),
    .smp_o  (sh_smp)
  );

  mwo_sine u_sine (
    .clk  (clk),
    .en   (en[mwo_pkg::ST_SINE +: NSS]),
    .x    (sh_x),
    .quad (sh_quad),
    .q_o  (sine_q)
  );

  // non-sine words ride alongside the sine pipeline
  always_ff @(posedge clk) begin
    if (en[mwo_pkg::ST_SINE]) begin
      side_op_r[0]  <= sh_op;
      side_smp_r[0] <= sh_smp;
    end
  end

  for (genvar i = 1; i < NSS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[mwo_pkg::ST_SINE + i]) begin
        side_op_r[i]  <= side_op_r[i-1];
        side_smp_r[i] <= side_smp_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[mwo_pkg::ST_OUT]) begin
      if (side_op_r[NSS-1] == mwo_pkg::OP_SINE) begin
        sample_r <= sine_q;
      end else begin
        sample_r <= side_smp_r[NSS-1];
      end
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = valid_r[NST-1];
  assign out_sample = sample_r;

endmodule

// ===== bench/multi_waveform_oscillator_check.sv =====
`timescale 1ns / 100ps

module multi_waveform_oscillator_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_time_value,
  input  logic [31:0]        in_frequency,
  input  logic signed [23:0] in_phase_offset,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_sample,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int PHASE_BITS = mwo_pkg::PHASE_FRAC_BITS_DEFAULT;
  localparam int TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEFAULT;

  localparam longint ONE_Q30 = longint'(1) << 30;
  localparam longint RAD_SCALE = 683565276;
  localparam longint K1 = 1686629713;
  localparam longint K3 = -693598668;
  localparam longint K5 = 85569306;
  localparam longint K7 = -5026995;
  localparam longint K9 = 172272;

  typedef struct {
    mwo_pkg::op_t       op;
    logic [31:0]        t;
    logic [31:0]        f;
    logic signed [23:0] off;
    logic signed [15:0] sample;
  } expected_sample_t;

  expected_sample_t expected_samples[$];
  expected_sample_t want;

  function automatic logic signed [15:0] oscillator_sample(mwo_pkg::op_t op,
                                                            logic [31:0] t,
                                                            logic [31:0] f,
                                                            logic signed [23:0] off);
    logic [63:0]        prod;
    logic signed [63:0] off_scaled;
    logic [31:0]        off_cycles;
    logic [31:0]        ph;
    int unsigned        idx;
    int unsigned        quad;
    int unsigned        frac;
    longint             x;
    longint             x2;
    longint             p;
    longint             y;
    longint             q;
    longint             d;
    prod = {32'd0, t} * {32'd0, f};
    if (op == mwo_pkg::OP_SINE) begin
      off_scaled = longint'(off) * RAD_SCALE;
      off_cycles = off_scaled[47:16];
    end else begin
      off_cycles = {off[15:0], 16'h0000};
    end
    ph = prod[31:0] + off_cycles;
    ph &= ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);
    case (op)
      mwo_pkg::OP_SINE: begin
        idx = ph >> (32 - TABLE_BITS);
        quad = (idx >> (TABLE_BITS - 2)) & 3;
        frac = idx & ((1 << (TABLE_BITS - 2)) - 1);
        x = longint'(frac) << (32 - TABLE_BITS);
        if (quad[0]) begin
          x = ONE_Q30 - x;
        end
        // odd polynomial in x, products truncated toward zero
        x2 = (x * x) / ONE_Q30;
        p = K9;
        p = K7 + (p * x2) / ONE_Q30;
        p = K5 + (p * x2) / ONE_Q30;
        p = K3 + (p * x2) / ONE_Q30;
        p = K1 + (p * x2) / ONE_Q30;
        y = (x * p) / ONE_Q30;
        if (y < 0) begin
          y = 0;
        end
        if (y > ONE_Q30) begin
          y = ONE_Q30;
        end
        q = (y + 16384) >>> 15;
        if (q > 32767) begin
          q = 32767;
        end
        if (quad[1]) begin
          q = -q;
        end
        return 16'(q);
      end
      mwo_pkg::OP_SAW: return ph[31:16];
      mwo_pkg::OP_SQUARE: return ph[31] ? 16'sh8000 : 16'sh7FFF;
      default: begin
        y = longint'(ph) - ONE_Q30;
        if (y < 0) begin
          d = -y;
        end else if (y <= 2 * ONE_Q30) begin
          d = y;
        end else begin
          d = 4 * ONE_Q30 - y;
        end
        q = 32768 - (d >>> 15);
        if (q > 32767) begin
          q = 32767;
        end
        return 16'(q);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_samples.push_back('{mwo_pkg::op_t'(in_op), in_time_value, in_frequency,
                                   in_phase_offset,
                                   oscillator_sample(mwo_pkg::op_t'(in_op), in_time_value,
                                                     in_frequency, in_phase_offset)});
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("word with no request waiting, sample %0d", out_sample));
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want.sample) begin
          report_mismatch($sformatf("%s time %h freq %h offset %h: sample %0d, want %0d",
                                    want.op.name(), want.t, want.f, want.off,
                                    out_sample, want.sample));
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// ===== bench/multi_waveform_oscillator_test.sv =====
`timescale 1ns / 100ps

module multi_waveform_oscillator_test;

  localparam int LONG_HOLD = 120;
  localparam int FLOOD = 60;
  localparam int TAIL_WAIT = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = 2'd0;
  logic [31:0]        in_time_value = 32'd0;
  logic [31:0]        in_frequency = 32'd0;
  logic signed [23:0] in_phase_offset = 24'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;

  int mismatches;
  int outstanding;
  int sent;
  bit send_gaps = 1'b1;
  bit ready_gaps = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_waveform_oscillator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_time_value(in_time_value),
    .in_frequency(in_frequency),
    .in_phase_offset(in_phase_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample)
  );

  multi_waveform_oscillator_check check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_time_value(in_time_value),
    .in_frequency(in_frequency),
    .in_phase_offset(in_phase_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0003_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [23:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'(int'($urandom_range(0, 262143)) - 131072);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_word(mwo_pkg::op_t op, logic [31:0] t, logic [31:0] f,
                           logic signed [23:0] off);
    in_valid <= 1'b1;
    in_op <= op;
    in_time_value <= t;
    in_frequency <= f;
    in_phase_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random();
    send_word(mwo_pkg::op_t'($urandom_range(0, 3)), pick_word(), pick_word(), pick_offset());
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      pause($urandom_range(1, 10));
    end
  endtask

  // output side: random stalls, one long hold on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (ready_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-ones time and frequency with both offset extremes for every waveform, product overflow
    for (int i = 0; i < 4; i++) begin
      send_word(mwo_pkg::op_t'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'sh7FFFFF);
      send_word(mwo_pkg::op_t'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'sh800000);
    end
    // sine: zero, quarter turn in radians, negative quarter turn
    send_word(mwo_pkg::OP_SINE, 32'd0, 32'd0, 24'sd0);
    send_word(mwo_pkg::OP_SINE, 32'd0, 32'd0, 24'sd102944);
    send_word(mwo_pkg::OP_SINE, 32'd0, 32'd0, -24'sd102944);
    send_word(mwo_pkg::OP_SAW, 32'd0, 32'd0, 24'sd0);
    send_word(mwo_pkg::OP_SAW, 32'd0, 32'd0, 24'sh008000);
    send_word(mwo_pkg::OP_SAW, 32'd0, 32'd0, -24'sd1);
    // square around half a cycle and with negative phase
    send_word(mwo_pkg::OP_SQUARE, 32'd0, 32'd0, 24'sh007FFF);
    send_word(mwo_pkg::OP_SQUARE, 32'd0, 32'd0, 24'sh008000);
    send_word(mwo_pkg::OP_SQUARE, 32'd0, 32'd0, -24'sh004000);
    // triangle: peak saturates, trough, zero phase, negative phase
    send_word(mwo_pkg::OP_TRIANGLE, 32'd0, 32'd0, 24'sh004000);
    send_word(mwo_pkg::OP_TRIANGLE, 32'd0, 32'd0, 24'sh00C000);
    send_word(mwo_pkg::OP_TRIANGLE, 32'd0, 32'd0, 24'sd0);
    send_word(mwo_pkg::OP_TRIANGLE, 32'd0, 32'd0, -24'sh004000);
    // one second at one and a half hertz
    send_word(mwo_pkg::OP_SQUARE, 32'h0001_0000, 32'h0001_8000, 24'sd0);
    drain();

    for (int i = 0; i < 500; i++) send_random();
    drain();

    // long output stall while words keep coming
    hold_req = 1'b1;
    send_gaps = 1'b0;
    repeat (FLOOD) send_random();
    send_gaps = 1'b1;
    drain();

    for (int i = 0; i < 700; i++) send_random();
    drain();

    // full rate, no stalls
    send_gaps = 1'b0;
    ready_gaps = 1'b0;
    for (int i = 0; i < 340; i++) send_random();
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d words across sine, saw, square and triangle", sent);
    $display("with random gaps on both sides, a %0d-cycle output stall and drain pauses",
             LONG_HOLD);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
